/* rtl/ddmm_pkg.sv */
// ----------------------------------------------------------------------------
// ddmm_pkg
// Shared widths, register indexes and pipeline types for the differential
// drive motor mixer.
// ----------------------------------------------------------------------------
package ddmm_pkg;

  localparam int DUTY_BITS = 12;
  localparam int FRAC_BITS = 12;
  localparam int CMD_W     = 16;
  localparam int DZ_W      = 14;
  localparam int CFG_W     = (DZ_W > DUTY_BITS) ? DZ_W : DUTY_BITS;
  localparam int IDX_W     = 2;

  // clamped command magnitude holds 1.0, signed square holds +-1.0
  localparam int WIDE_W = ((CMD_W > FRAC_BITS) ? CMD_W : FRAC_BITS) + 2;
  localparam int MAG1_W = FRAC_BITS + 1;
  localparam int P_W    = FRAC_BITS + 2;
  // wheel movement spans +-2.0
  localparam int MOV_W  = FRAC_BITS + 3;
  localparam int MAG_W  = FRAC_BITS + 2;
  localparam int CMP_W  = (MAG_W > DZ_W) ? MAG_W : DZ_W;

  // square root unit: radicand is |m| << FRAC_BITS, padded to an even width
  localparam int SQRT_STAGES = 4;
  localparam int RAW_ROOT_W  = (MAG_W + FRAC_BITS + 1) / 2;
  localparam int STEPS_PER   = (RAW_ROOT_W + SQRT_STAGES - 1) / SQRT_STAGES;
  localparam int ROOT_W      = SQRT_STAGES * STEPS_PER;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int REM_W       = ROOT_W + 3;

  localparam int PROD_W  = ROOT_W + DUTY_BITS;
  localparam int SCALE_W = PROD_W - FRAC_BITS;
  localparam int SUM_W   = ((SCALE_W > DUTY_BITS) ? SCALE_W : DUTY_BITS) + 1;

  typedef enum logic [IDX_W-1:0] {
    REG_DUTY_MIN  = 2'd0,
    REG_DUTY_MAX  = 2'd1,
    REG_DEAD_ZONE = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic pos;
    logic neg;
    logic off;
  } wheel_flags_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_state_t;

endpackage

/* rtl/diff_drive_motor_mixer_unit.sv */
// ----------------------------------------------------------------------------
// diff_drive_motor_mixer_unit
// Arcade mixing of linear/angular commands into bridge pin levels and PWM
// duties for the two wheels of a differential drive.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready carrying linear_cmd and angular_cmd
//   (signed Q3.12). Each request yields one result on out_valid/out_ready:
//   four bridge pin levels and a 12-bit duty per wheel.
//   Eight register stages: clamp and square, mixing and magnitude, four
//   square-root stages of four bits each, the span multiply, and the duty
//   saturation into the output register. Throughput is one request per
//   cycle while out_ready stays high. When the receiver stalls, the whole
//   pipeline holds in place and in_ready drops; nothing is lost or repeated.
//   Reset clears all valid bits and loads duty_min = 750, duty_max = 1023,
//   dead_zone = 41. Registers are written through cfg_wr_en/cfg_index/
//   cfg_data; unknown indexes are ignored. The user must write them only
//   while the pipeline is empty; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module diff_drive_motor_mixer_unit
  import ddmm_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [IDX_W-1:0]            cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [CMD_W-1:0]     linear_cmd,
  input  logic signed [CMD_W-1:0]     angular_cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        left_pin_a,
  output logic                        left_pin_b,
  output logic                        right_pin_a,
  output logic                        right_pin_b,
  output logic [DUTY_BITS-1:0]        left_duty,
  output logic [DUTY_BITS-1:0]        right_duty
);

  localparam logic signed [WIDE_W-1:0] ONE_POS = WIDE_W'(1) <<< FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] ONE_NEG = -ONE_POS;

  // configuration registers
  logic [DUTY_BITS-1:0] duty_min;
  logic [DUTY_BITS-1:0] duty_max;
  logic [DZ_W-1:0]      dead_zone;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_min  <= DUTY_BITS'(750);
      duty_max  <= DUTY_BITS'(1023);
      dead_zone <= DZ_W'(41);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DUTY_MIN:  duty_min  <= cfg_data[DUTY_BITS-1:0];
        REG_DUTY_MAX:  duty_max  <= cfg_data[DUTY_BITS-1:0];
        REG_DEAD_ZONE: dead_zone <= cfg_data[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances together
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  function automatic logic signed [P_W-1:0] signed_square(
    input logic signed [CMD_W-1:0] cmd
  );
    logic signed [WIDE_W-1:0]  c;
    logic                      neg;
    logic [WIDE_W-1:0]         abs_c;
    logic [MAG1_W-1:0]         mag;
    logic [2*MAG1_W-1:0]       sq;
    logic signed [P_W-1:0]     p;
    c     = WIDE_W'(cmd);
    neg   = c < 0;
    abs_c = neg ? WIDE_W'(-c) : WIDE_W'(c);
    if (c > ONE_POS || c < ONE_NEG) begin
      mag = MAG1_W'(ONE_POS);
    end else begin
      mag = abs_c[MAG1_W-1:0];
    end
    sq = (2*MAG1_W)'(mag) * (2*MAG1_W)'(mag);
    p  = P_W'(sq[2*FRAC_BITS:FRAC_BITS]);
    return neg ? -p : p;
  endfunction

  function automatic sqrt_state_t sqrt_steps(input sqrt_state_t st);
    sqrt_state_t       s;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    s = st;
    for (int i = 0; i < STEPS_PER; i++) begin
      rem_sh = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
      s.rad  = s.rad << 2;
      trial  = REM_W'({s.root, 2'b01});
      if (rem_sh >= trial) begin
        s.rem  = rem_sh - trial;
        s.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
        s.rem  = rem_sh;
        s.root = {s.root[ROOT_W-2:0], 1'b0};
      end
    end
    return s;
  endfunction

  // stage 1: clamp and signed square
  logic                  v1;
  logic signed [P_W-1:0] lin_p;
  logic signed [P_W-1:0] ang_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lin_p <= signed_square(linear_cmd);
      ang_p <= signed_square(angular_cmd);
    end
  end

  // stage 2: mix, magnitude, pins and dead zone; seed the root unit
  logic signed [MOV_W-1:0] mov [2];
  wheel_flags_t            flags_next [2];
  sqrt_state_t             seed_next [2];

  always_comb begin
    mov[0] = MOV_W'(lin_p) - MOV_W'(ang_p);
    mov[1] = MOV_W'(lin_p) + MOV_W'(ang_p);
    for (int w = 0; w < 2; w++) begin
      logic [MOV_W-1:0] abs_m;
      logic [MAG_W-1:0] mag;
      abs_m = (mov[w] < 0) ? MOV_W'(-mov[w]) : MOV_W'(mov[w]);
      mag   = abs_m[MAG_W-1:0];
      flags_next[w].pos = mov[w] > 0;
      flags_next[w].neg = mov[w] < 0;
      flags_next[w].off = CMP_W'(mag) < CMP_W'(dead_zone);
      seed_next[w].rad  = RAD_W'({mag, {FRAC_BITS{1'b0}}});
      seed_next[w].rem  = '0;
      seed_next[w].root = '0;
    end
  end

  // index 0 holds stage 2, indexes 1..SQRT_STAGES the root stages
  logic         sv  [SQRT_STAGES+1];
  wheel_flags_t sfl [SQRT_STAGES+1][2];
  sqrt_state_t  sst [SQRT_STAGES+1][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQRT_STAGES; k++) begin
        sv[k] <= 1'b0;
      end
    end else if (adv) begin
      sv[0] <= v1;
      for (int k = 1; k <= SQRT_STAGES; k++) begin
        sv[k] <= sv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int w = 0; w < 2; w++) begin
        sfl[0][w] <= flags_next[w];
        sst[0][w] <= seed_next[w];
        for (int k = 1; k <= SQRT_STAGES; k++) begin
          sfl[k][w] <= sfl[k-1][w];
          sst[k][w] <= sqrt_steps(sst[k-1][w]);
        end
      end
    end
  end

  // span multiply
  logic              v7;
  wheel_flags_t      fl7 [2];
  logic [PROD_W-1:0] prod [2];
  logic [DUTY_BITS-1:0] span;
  assign span = duty_max - duty_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= sv[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int w = 0; w < 2; w++) begin
        fl7[w]  <= sfl[SQRT_STAGES][w];
        prod[w] <= PROD_W'(sst[SQRT_STAGES][w].root) * PROD_W'(span);
      end
    end
  end

  // offset, saturate and zero into the output register
  logic [DUTY_BITS-1:0] duty_next [2];

  always_comb begin
    for (int w = 0; w < 2; w++) begin
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(duty_min) + SUM_W'(prod[w][PROD_W-1:FRAC_BITS]);
      if (fl7[w].off || duty_min > duty_max) begin
        duty_next[w] = '0;
      end else if (sum > SUM_W'(duty_max)) begin
        duty_next[w] = duty_max;
      end else begin
        duty_next[w] = sum[DUTY_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left_pin_a  <= fl7[0].pos;
      left_pin_b  <= fl7[0].neg;
      right_pin_a <= fl7[1].neg;
      right_pin_b <= fl7[1].pos;
      left_duty   <= duty_next[0];
      right_duty  <= duty_next[1];
    end
  end

  // checks
  a_left_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && left_duty != '0 |-> left_duty >= duty_min && left_duty <= duty_max)
    else $error("left duty outside configured range");

  a_pins_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(left_pin_a && left_pin_b) && !(right_pin_a && right_pin_b))
    else $error("bridge pins both high");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted request missing from first stage");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for diff_drive_motor_mixer_unit. A directed table covers
// the command extremes, clamping, zero movement and the dead-zone edge; random
// commands then run under a sequence of duty/dead-zone settings. Each result is taken
// from the table or predicted in the bench, and is compared field by field.
// ----------------------------------------------------------------------------
module tb_top
  import ddmm_pkg::*;
;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int RUN_LIMIT    = 400000;
  localparam int PHASES       = 12;
  localparam int PHASE_CMDS   = 100;
  localparam int DRAIN_CYCLES = 24;
  localparam int N_ROWS       = 24;
  localparam int N_SETTINGS   = 6;

  typedef struct packed {
    logic                 lpa;
    logic                 lpb;
    logic                 rpa;
    logic                 rpb;
    logic [DUTY_BITS-1:0] ld;
    logic [DUTY_BITS-1:0] rd;
  } bridge_out_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] lin;
    logic signed [CMD_W-1:0] ang;
    logic                    known;
    bridge_out_t             res;
  } cmd_row_t;

  typedef struct packed {
    logic [CFG_W-1:0] dmin;
    logic [CFG_W-1:0] dmax;
    logic [CFG_W-1:0] dz;
  } duty_setting_t;

  // Known results hold for the reset setting: min 750, max 1023, dead zone 41
  localparam cmd_row_t CMD_TABLE [N_ROWS] = '{
    '{16'sd0,      16'sd0,      1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 12'd0,    12'd0}},
    '{16'sd4096,   16'sd0,      1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 12'd1023, 12'd1023}},
    '{16'sd32767,  16'sd0,      1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 12'd1023, 12'd1023}},
    '{-16'sd32768, 16'sd0,      1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 12'd1023, 12'd1023}},
    '{16'sd0,      16'sd4096,   1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 12'd1023, 12'd1023}},
    '{16'sd0,      -16'sd32768, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 12'd1023, 12'd1023}},
    '{16'sd4096,   16'sd4096,   1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 12'd0,    12'd1023}},
    '{-16'sd32768, 16'sd32767,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 12'd1023, 12'd0}},
    '{16'sd400,    16'sd0,      1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 12'd0,    12'd0}},
    '{-16'sd400,   16'sd0,      1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 12'd0,    12'd0}},
    '{16'sd0,      16'sd400,    1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 12'd0,    12'd0}},
    '{16'sd410,    16'sd0,      1'b0, '0},
    '{16'sd409,    16'sd0,      1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 12'd0,    12'd0}},
    '{16'sd4097,   -16'sd4097,  1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 12'd1023, 12'd0}},
    '{16'sd1,      16'sd1,      1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 12'd0,    12'd0}},
    '{-16'sd1,     -16'sd1,     1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 12'd0,    12'd0}},
    '{16'sd1000,   -16'sd3000,  1'b0, '0},
    '{-16'sd12345, 16'sd2222,   1'b0, '0},
    '{16'sd2896,   16'sd2896,   1'b0, '0},
    '{16'sd3000,   -16'sd1000,  1'b0, '0},
    '{-16'sd2048,  -16'sd2048,  1'b0, '0},
    '{16'sd16384,  -16'sd200,   1'b0, '0},
    '{16'sd64,     16'sd4095,   1'b0, '0},
    '{16'sd32767,  -16'sd32768, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 12'd1023, 12'd0}}
  };

  // Fixed settings for the first random phases; later phases draw their own
  localparam duty_setting_t DUTY_SETTINGS [N_SETTINGS] = '{
    '{14'd0,     14'd4095,  14'd0},
    '{14'd4095,  14'd4095,  14'd8192},
    '{14'd4095,  14'd0,     14'd41},
    '{14'd0,     14'd0,     14'h3FFF},
    '{14'h3FFF,  14'h2ABC,  14'd1},
    '{14'd1,     14'd4094,  14'd8191}
  };

  logic                    clk;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [CMD_W-1:0] linear_cmd;
  logic signed [CMD_W-1:0] angular_cmd;
  logic                    out_valid;
  logic                    out_ready;
  logic                    left_pin_a;
  logic                    left_pin_b;
  logic                    right_pin_a;
  logic                    right_pin_b;
  logic [DUTY_BITS-1:0]    left_duty;
  logic [DUTY_BITS-1:0]    right_duty;

  logic [DUTY_BITS-1:0] min_sh;
  logic [DUTY_BITS-1:0] max_sh;
  logic [DZ_W-1:0]      dz_sh;

  bridge_out_t pending_mix[$];
  logic        row_known;
  bridge_out_t row_res;
  int          cycles;
  int          errors;

  diff_drive_motor_mixer_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .linear_cmd  (linear_cmd),
    .angular_cmd (angular_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_pin_a  (left_pin_a),
    .left_pin_b  (left_pin_b),
    .right_pin_a (right_pin_a),
    .right_pin_b (right_pin_b),
    .left_duty   (left_duty),
    .right_duty  (right_duty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp to +-1.0, then square keeping the sign (truncated toward zero)
  function automatic int clamp_sq(input logic signed [CMD_W-1:0] c);
    int one;
    int v;
    int mag;
    one = 1 << FRAC_BITS;
    v = c;
    if (v > one) v = one;
    if (v < -one) v = -one;
    mag = (v < 0) ? -v : v;
    mag = (mag * mag) >> FRAC_BITS;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic logic [DUTY_BITS-1:0] wheel_duty_of(input int m);
    longint unsigned mag;
    longint unsigned rad;
    longint unsigned root;
    longint unsigned trial;
    longint unsigned span;
    longint unsigned d;
    int              b;
    mag = (m < 0) ? 64'(-m) : 64'(m);
    if (mag < 64'(dz_sh) || min_sh > max_sh) return '0;
    rad = mag << FRAC_BITS;
    root = 0;
    // floor square root, one result bit at a time
    for (b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= rad) root = trial;
    end
    span = 64'(max_sh) - 64'(min_sh);
    d = 64'(min_sh) + ((root * span) >> FRAC_BITS);
    if (d > 64'(max_sh)) d = 64'(max_sh);
    return d[DUTY_BITS-1:0];
  endfunction

  function automatic bridge_out_t mix_predict(input logic signed [CMD_W-1:0] lin,
                                              input logic signed [CMD_W-1:0] ang);
    bridge_out_t r;
    int          lp;
    int          ap;
    int          lm;
    int          rm;
    lp = clamp_sq(lin);
    ap = clamp_sq(ang);
    lm = lp - ap;
    rm = lp + ap;
    r.lpa = (lm > 0);
    r.lpb = (lm < 0);
    // right wheel runs mirrored
    r.rpa = (rm < 0);
    r.rpb = (rm > 0);
    r.ld  = wheel_duty_of(lm);
    r.rd  = wheel_duty_of(rm);
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_len(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic signed [CMD_W-1:0] rand_cmd();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 8192) - 4096;
      4, 5:       v = $urandom;
      6, 7:       v = $urandom_range(0, 1400) - 700;
      default: begin
        case ($urandom_range(0, 7))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = -4097;
          3:       v = -4096;
          4:       v = 4096;
          5:       v = 4097;
          6:       v = -1;
          default: v = 0;
        endcase
      end
    endcase
    return v[CMD_W-1:0];
  endfunction

  task automatic check_field(input string name, input logic [DUTY_BITS-1:0] want,
                             input logic [DUTY_BITS-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic send_cmd(input logic signed [CMD_W-1:0] lin,
                          input logic signed [CMD_W-1:0] ang,
                          input logic known, input bridge_out_t res, input int gap);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    linear_cmd  <= lin;
    angular_cmd <= ang;
    row_known   = known;
    row_res     = res;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop the request line and hold until every result is back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: random stalls, with stretches of steady acceptance
  initial begin
    int  mode_left;
    int  hold_left;
    bit  rx_steady;
    out_ready = 1'b0;
    mode_left = 0;
    hold_left = 0;
    rx_steady = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      mode_left--;
      if (hold_left == 0 && !rx_steady && $urandom_range(0, 2) == 0)
        hold_left = gap_len(1'b0);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    bridge_out_t want;
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("** diff_drive_motor_mixer_unit: FAILED **");
      $finish;
    end else if (rst) begin
      // reset values of the configuration registers
      min_sh = 12'd750;
      max_sh = 12'd1023;
      dz_sh  = 14'd41;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_DUTY_MIN:  min_sh = cfg_data[DUTY_BITS-1:0];
          REG_DUTY_MAX:  max_sh = cfg_data[DUTY_BITS-1:0];
          REG_DEAD_ZONE: dz_sh  = cfg_data[DZ_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_mix.push_back(row_known ? row_res : mix_predict(linear_cmd, angular_cmd));
      if (out_valid && out_ready) begin
        if (pending_mix.size() == 0) begin
          errors++;
          $display("%0t: result with no request outstanding", $time);
        end else begin
          want = pending_mix.pop_front();
          check_field("left_pin_a",  DUTY_BITS'(want.lpa), DUTY_BITS'(left_pin_a));
          check_field("left_pin_b",  DUTY_BITS'(want.lpb), DUTY_BITS'(left_pin_b));
          check_field("right_pin_a", DUTY_BITS'(want.rpa), DUTY_BITS'(right_pin_a));
          check_field("right_pin_b", DUTY_BITS'(want.rpb), DUTY_BITS'(right_pin_b));
          check_field("left_duty",   want.ld,  left_duty);
          check_field("right_duty",  want.rd,  right_duty);
        end
      end
    end
  end

  initial begin
    duty_setting_t s;
    int            ph;
    int            k;
    bit            tx_quiet;
    cycles      = 0;
    errors      = 0;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_index   = REG_DUTY_MIN;
    cfg_data    = '0;
    in_valid    = 1'b0;
    linear_cmd  = '0;
    angular_cmd = '0;
    row_known   = 1'b0;
    row_res     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < N_ROWS; k++)
      send_cmd(CMD_TABLE[k].lin, CMD_TABLE[k].ang, CMD_TABLE[k].known, CMD_TABLE[k].res,
               gap_len(1'b0));

    for (ph = 1; ph < PHASES; ph++) begin
      settle();
      if (ph <= N_SETTINGS) begin
        s = DUTY_SETTINGS[ph-1];
      end else begin
        s.dmin = CFG_W'($urandom_range(0, 4095));
        s.dmax = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom_range(0, 4095))
                                             : CFG_W'($urandom_range(s.dmin, 4095));
        s.dz   = CFG_W'($urandom_range(0, 8192));
      end
      write_reg(REG_DUTY_MIN, s.dmin);
      write_reg(REG_DUTY_MAX, s.dmax);
      write_reg(REG_DEAD_ZONE, s.dz);
      // unmapped index must leave the setting untouched
      if (ph == N_SETTINGS) write_reg(REG_SPARE, CFG_W'($urandom));
      tx_quiet = (ph % 3 == 1);
      for (k = 0; k < PHASE_CMDS; k++) begin
        if (ph == 7 && k == PHASE_CMDS / 2) settle();
        send_cmd(rand_cmd(), rand_cmd(), 1'b0, '0, gap_len(tx_quiet));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("** diff_drive_motor_mixer_unit: PASSED **");
    else
      $display("** diff_drive_motor_mixer_unit: FAILED **");
    $finish;
  end

endmodule
